// ===== rtl/core/sspp_pkg.sv =====
// Shared types for the servo status packet parser.
package sspp_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [7:0] LEN_BIAS  = 8'd2;

  typedef enum logic [2:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_ID,
    PH_LEN,
    PH_ERR,
    PH_ARGS,
    PH_CSUM
  } phase_t;

  typedef enum logic {
    KIND_ARG = 1'b0,
    KIND_END = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] servo_id;
    logic [7:0] error_flags;
    logic [7:0] arg_index;
    logic [7:0] arg_value;
    logic       checksum_ok;
  } res_t;

endpackage

// ===== rtl/core/sspp_fsm.sv =====
// Packet parse state machine: phase, header fields, argument count and running sum.
module sspp_fsm (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [7:0]      rx_byte,
  input  logic            check_enable,
  output logic            res_valid,
  output sspp_pkg::res_t  res
);
  import sspp_pkg::*;

  phase_t     phase, phase_next;
  logic [7:0] packet_id, packet_error, arg_total, arg_seen, running_sum;
  logic [7:0] packet_id_next, packet_error_next, arg_total_next, arg_seen_next;
  logic [7:0] running_sum_next;
  logic       sum_match;

  assign sum_match = (rx_byte == ~running_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SYNC1;
      packet_id    <= '0;
      packet_error <= '0;
      arg_total    <= '0;
      arg_seen     <= '0;
      running_sum  <= '0;
    end else if (step) begin
      phase        <= phase_next;
      packet_id    <= packet_id_next;
      packet_error <= packet_error_next;
      arg_total    <= arg_total_next;
      arg_seen     <= arg_seen_next;
      running_sum  <= running_sum_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    packet_id_next    = packet_id;
    packet_error_next = packet_error;
    arg_total_next    = arg_total;
    arg_seen_next     = arg_seen;
    running_sum_next  = running_sum;
    res_valid         = 1'b0;
    res.kind          = KIND_ARG;
    res.servo_id      = packet_id;
    res.error_flags   = packet_error;
    res.arg_index     = arg_seen;
    res.arg_value     = rx_byte;
    res.checksum_ok   = 1'b0;
    case (phase)
      PH_SYNC1: begin
        if (rx_byte == SYNC_BYTE) phase_next = PH_SYNC2;
      end
      // junk between the syncs keeps us waiting for the second one
      PH_SYNC2: begin
        if (rx_byte == SYNC_BYTE) phase_next = PH_ID;
      end
      PH_ID: begin
        packet_id_next   = rx_byte;
        running_sum_next = rx_byte;
        phase_next       = PH_LEN;
      end
      PH_LEN: begin
        arg_total_next   = rx_byte - LEN_BIAS;  // wraps for short lengths
        running_sum_next = running_sum + rx_byte;
        arg_seen_next    = '0;
        phase_next       = PH_ERR;
      end
      PH_ERR: begin
        packet_error_next = rx_byte;
        running_sum_next  = running_sum + rx_byte;
        phase_next        = (arg_total != '0) ? PH_ARGS : PH_CSUM;
      end
      PH_ARGS: begin
        res_valid        = 1'b1;
        running_sum_next = running_sum + rx_byte;
        arg_seen_next    = arg_seen + 8'd1;
        if (arg_seen_next == arg_total) phase_next = PH_CSUM;
      end
      default: begin
        res_valid       = 1'b1;
        res.kind        = KIND_END;
        res.arg_index   = arg_total;
        res.arg_value   = '0;
        res.checksum_ok = !check_enable || sum_match;
        phase_next      = PH_SYNC1;
      end
    endcase
  end

endmodule

// ===== rtl/core/servo_status_packet_parser_unit.sv =====
// Top level of the servo status packet parser.
// An accepted byte is held in the input register; its result goes to the result register.
// Throughput: one byte per cycle, set by these two registers, unless a result is stalled.
// The result register is freed in the same cycle it is taken, so no bubble on stalls.
// Reset (rst, synchronous): parser waits for the first sync, header state cleared,
// check_enable set to 1, both pipeline registers empty.
module servo_status_packet_parser_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       kind,
  output logic [7:0] servo_id,
  output logic [7:0] error_flags,
  output logic [7:0] arg_index,
  output logic [7:0] arg_value,
  output logic       checksum_ok
);
  import sspp_pkg::*;

  logic       check_enable;
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_adv;
  logic       has_result;
  res_t       res;
  res_t       out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) check_enable <= 1'b1;
    else if (cfg_valid) check_enable <= cfg_data;
  end

  // a byte with no result leaves stage 1 even while the output is stalled
  assign s1_adv   = s1_valid && (!out_valid || out_ready || !has_result);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_byte <= rx_byte;
  end

  sspp_fsm u_fsm (
    .clk          (clk),
    .rst          (rst),
    .step         (s1_adv),
    .rx_byte      (s1_byte),
    .check_enable (check_enable),
    .res_valid    (has_result),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && has_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && has_result) out_res <= res;
  end

  assign kind        = out_res.kind;
  assign servo_id    = out_res.servo_id;
  assign error_flags = out_res.error_flags;
  assign arg_index   = out_res.arg_index;
  assign arg_value   = out_res.arg_value;
  assign checksum_ok = out_res.checksum_ok;

endmodule

// ===== rtl/core/sspp_checker.sv =====
// Port-level checks for the servo status packet parser, bound to the top level.
module sspp_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       kind,
  input logic [7:0] servo_id,
  input logic [7:0] error_flags,
  input logic [7:0] arg_index,
  input logic [7:0] arg_value,
  input logic       checksum_ok
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(servo_id) &&
      $stable(error_flags) && $stable(arg_index) && $stable(arg_value) &&
      $stable(checksum_ok))
    else $error("stalled result changed");

  a_arg_no_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind |-> !checksum_ok)
    else $error("argument item carries checksum flag");

  a_end_no_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind |-> arg_value == 8'd0)
    else $error("packet end item carries argument value");

endmodule

bind servo_status_packet_parser_unit sspp_checker u_sspp_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .kind        (kind),
  .servo_id    (servo_id),
  .error_flags (error_flags),
  .arg_index   (arg_index),
  .arg_value   (arg_value),
  .checksum_ok (checksum_ok)
);
